// ===== rtl/sms_pkg.sv =====
// Shared types, constants and sigma functions for the SHA-512 message schedule unit.
`timescale 1ns / 1ps

package sms_pkg;

  localparam int WORD_W      = 64;
  localparam int IDX_W       = 7;
  localparam int BLOCK_WORDS = 16;
  localparam int LOAD_W      = 4;
  localparam int STEP_W      = 6;

  localparam logic [LOAD_W-1:0] LAST_SLOT   = 4'd15;
  localparam logic [STEP_W-1:0] LAST_STEP   = 6'd63;
  localparam logic [IDX_W-1:0]  FIRST_INDEX = 7'd16;

  // Window taps, oldest word at position 0: w[i-16], w[i-15], w[i-7], w[i-2]
  localparam int TAP_W16 = 0;
  localparam int TAP_W15 = 1;
  localparam int TAP_W7  = 9;
  localparam int TAP_W2  = 14;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t word;
    logic  last;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic word_t small_sigma0(input word_t x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'b0, x[63:7]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'b0, x[63:6]};
  endfunction

  // Four-operand sum: two carry-save levels, then one carry-propagate add
  function automatic word_t add4(input word_t a, input word_t b, input word_t c,
                                 input word_t d);
    word_t s1;
    word_t c1;
    word_t s2;
    word_t c2;
    s1 = a ^ b ^ c;
    c1 = ((a & b) | (a & c) | (b & c)) << 1;
    s2 = s1 ^ c1 ^ d;
    c2 = ((s1 & c1) | (s1 & d) | (c1 & d)) << 1;
    return s2 + c2;
  endfunction

endpackage

// ===== rtl/sms_front.sv =====
// Front end: accept requests, tag the last word of each block.
`timescale 1ns / 1ps

module sms_front
  import sms_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t message_word,
  input  qstat_t qstat,
  output logic  busy,
  output push_t push
);

  logic [LOAD_W-1:0] words_loaded;
  logic              accept;

  assign busy   = qstat.full;
  assign accept = start && !qstat.full;

  assign push.valid      = accept;
  assign push.entry.word = message_word;
  assign push.entry.last = (words_loaded == LAST_SLOT);

  // Count words of the current block; wraps to zero after the sixteenth
  always_ff @(posedge clk) begin
    if (rst) begin
      words_loaded <= '0;
    end else if (accept) begin
      words_loaded <= words_loaded + 1'b1;
    end
  end

endmodule

// ===== rtl/sms_queue.sv =====
// Short word queue between the front end and the expansion back end.
`timescale 1ns / 1ps

module sms_queue
  import sms_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output qstat_t  qstat,
  output qentry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  qentry_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign qstat.full  = (count == CNT_FULL);
  assign qstat.empty = (count == '0);
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sms_back.sv =====
// Back end: load window and expansion window, one schedule word per cycle.
`timescale 1ns / 1ps

module sms_back
  import sms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  qentry_t          head,
  input  qstat_t           qstat,
  output logic             pop,
  output logic             result_valid,
  output word_t            schedule_word,
  output logic [IDX_W-1:0] schedule_index,
  output logic             run_last
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_EXPAND = 1'b1;

  logic              state;
  logic [STEP_W-1:0] step;
  word_t             load_win     [BLOCK_WORDS];
  word_t             load_win_next[BLOCK_WORDS];
  word_t             exp_win      [BLOCK_WORDS];
  word_t             new_word;
  logic              finishing;
  logic              launch;

  assign finishing = (state == ST_EXPAND) && (step == LAST_STEP);
  // A block's last word waits until the expansion window frees up
  assign pop    = !qstat.empty && (!head.last || state == ST_IDLE || finishing);
  assign launch = pop && head.last;

  always_comb begin
    for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
      load_win_next[k] = load_win[k + 1];
    end
    load_win_next[BLOCK_WORDS - 1] = head.word;
  end

  assign new_word = add4(exp_win[TAP_W16], small_sigma0(exp_win[TAP_W15]),
                         exp_win[TAP_W7], small_sigma1(exp_win[TAP_W2]));

  always_ff @(posedge clk) begin
    if (pop) begin
      load_win <= load_win_next;
    end
    if (launch) begin
      exp_win <= load_win_next;
    end else if (state == ST_EXPAND) begin
      for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
        exp_win[k] <= exp_win[k + 1];
      end
      exp_win[BLOCK_WORDS - 1] <= new_word;
    end
    schedule_word  <= new_word;
    schedule_index <= FIRST_INDEX + {1'b0, step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
      run_last     <= 1'b0;
    end else begin
      result_valid <= (state == ST_EXPAND);
      run_last     <= finishing;
      if (launch) begin
        state <= ST_EXPAND;
        step  <= '0;
      end else if (finishing) begin
        state <= ST_IDLE;
        step  <= '0;
      end else if (state == ST_EXPAND) begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sha512_message_schedule_unit.sv =====
// Top level of the SHA-384/512 message schedule expansion unit.
`timescale 1ns / 1ps

// Feed the sixteen 64-bit words of a message block, word 0 first, one per
// request (start high while busy is low). After the sixteenth word the unit
// emits schedule words w[16]..w[79] in order, one per clock on consecutive
// cycles, each marked by result_valid for exactly one cycle; run_last flags
// w[79]. The receiver cannot stall the unit, so capture every strobed cycle.
// Words are taken one per cycle while the front queue (QUEUE_DEPTH
// entries) has room. Expansion produces one word per cycle from a single
// four-operand adder; when the unit was idle, taking the sixteenth word
// loads the expansion window, and the first result is then registered
// out from it. The next block loads into a separate window during
// expansion; busy rises when the queue fills behind a running expansion.

module sha512_message_schedule_unit
  import sms_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [63:0]      message_word,
  output logic             result_valid,
  output logic [63:0]      schedule_word,
  output logic [IDX_W-1:0] schedule_index,
  output logic             run_last
);

  push_t   push;
  qstat_t  qstat;
  qentry_t head;
  logic    pop;

  // Accept and tag requests
  sms_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .message_word (message_word),
    .qstat        (qstat),
    .busy         (busy),
    .push         (push)
  );

  // Decouple accepts from the expansion
  sms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  // Load windows and expand
  sms_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .result_valid   (result_valid),
    .schedule_word  (schedule_word),
    .schedule_index (schedule_index),
    .run_last       (run_last)
  );

endmodule

// ===== rtl/sms_checker.sv =====
// Port-level checker for the message schedule unit, with its bind.
`timescale 1ns / 1ps

module sms_checker
  import sms_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic [IDX_W-1:0] schedule_index,
  input logic             run_last
);

  // A run opens at index 16
  a_run_opens: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> schedule_index == FIRST_INDEX)
    else $error("schedule run did not open at index 16");

  // Results of a run come on consecutive cycles with rising index
  a_run_steps: assert property (@(posedge clk) disable iff (rst)
    result_valid && !run_last |=>
      result_valid && schedule_index == $past(schedule_index) + 7'd1)
    else $error("schedule run broke or skipped an index");

  // The last mark rides only on a strobed word 79
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    run_last |-> result_valid && schedule_index == 7'd79)
    else $error("run_last outside word 79");

  // Index 79 always closes the run
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && schedule_index == 7'd79 |-> run_last)
    else $error("word 79 without run_last");

endmodule

bind sha512_message_schedule_unit sms_checker u_sms_checker (.*);
